/* rtl/ltx_pkg.sv */
// Shared types and codes for the LT encoded symbol XOR block.
`timescale 1ns / 1ps

package ltx_pkg;

    localparam int SYM_W  = 6;
    localparam int POS_W  = 4;
    localparam int BYTE_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_XOR  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SYM_W-1:0]  sym_index;
        logic [POS_W-1:0]  byte_pos;
        logic [BYTE_W-1:0] byte_value;
        logic              last_neighbor;
    } ltx_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  out_pos;
        logic              last_byte;
    } ltx_out_t;

endpackage

/* rtl/ltx_src_store.sv */
// Byte-wide source symbol store: one write port, one registered read port.
`timescale 1ns / 1ps

module ltx_src_store import ltx_pkg::*; #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lt_encoded_symbol_xor.sv */
// LT encoder core: source store, byte-serial XOR accumulator and output sequencer.
//
// Input channel s_valid/s_ready/s_data carries requests of type ltx_in_t.
// A load (op = 0) writes one source byte if its symbol and position are in range.
// An xor request (op = 1) walks the named source row one byte per cycle
// through the single store read port and the shared byte XOR unit; a symbol
// number out of range skips the walk.
// When the request carries last_neighbor, the accumulator is emitted on
// m_valid/m_ready/m_data as SYMBOL_BYTES requests in position order, the
// final one flagged last_byte, each byte cleared as it leaves. A stall of
// the receiver holds the output register and pauses the sequencer.
// s_ready is high only while the sequencer is idle; the last output byte
// may still wait in the output register while new requests are taken.
// Reset clears the sequencer, the output valid and the accumulator. The
// source store is not cleared: reading a row never loaded is undefined.
`timescale 1ns / 1ps

module lt_encoded_symbol_xor import ltx_pkg::*; #(
    parameter int NUM_SOURCE   = 64,
    parameter int SYMBOL_BYTES = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ltx_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ltx_out_t m_data
);

    localparam int DEPTH  = NUM_SOURCE * SYMBOL_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(SYMBOL_BYTES + 1);
    localparam int IDX_W  = (SYMBOL_BYTES > 1) ? $clog2(SYMBOL_BYTES) : 1;
    localparam int WIDE_W = SYM_W + CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SYMBOL_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SYMBOL_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_XOR  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] acc_reg [SYMBOL_BYTES];
    logic              m_valid_reg;
    ltx_out_t          m_data_reg;

    logic              accept;
    logic              sym_ok;
    logic              pos_ok;
    logic [WIDE_W-1:0] row_base;
    logic [ADDR_W-1:0] ld_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic [CNT_W-1:0]  cnt_m1;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign sym_ok   = (32'(s_data.sym_index) < NUM_SOURCE);
    assign pos_ok   = (32'(s_data.byte_pos) < SYMBOL_BYTES);
    assign row_base = WIDE_W'(s_data.sym_index) * WIDE_W'(SYMBOL_BYTES);
    assign ld_addr  = ADDR_W'(row_base + WIDE_W'(s_data.byte_pos));
    assign rd_addr  = base_reg + ADDR_W'(cnt_reg);
    assign rd_en    = (state_reg == ST_XOR) && (cnt_reg < CNT_END);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    ltx_src_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && (s_data.op == OP_LOAD) && sym_ok && pos_ok),
        .wr_addr (ld_addr),
        .wr_data (s_data.byte_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SYMBOL_BYTES; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_data.op == OP_XOR)) begin
                        base_reg <= ADDR_W'(row_base);
                        last_reg <= s_data.last_neighbor;
                        cnt_reg  <= '0;
                        if (sym_ok) begin
                            state_reg <= ST_XOR;
                        end else if (s_data.last_neighbor) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_XOR: begin
                    if (cnt_reg != '0) begin
                        acc_reg[cnt_m1[IDX_W-1:0]] <= acc_reg[cnt_m1[IDX_W-1:0]] ^ rd_data;
                    end
                    if (cnt_reg == CNT_END) begin
                        cnt_reg   <= '0;
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.out_byte  <= acc_reg[cnt_reg[IDX_W-1:0]];
                        m_data_reg.out_pos   <= POS_W'(cnt_reg);
                        m_data_reg.last_byte <= (cnt_reg == CNT_LAST);
                        acc_reg[cnt_reg[IDX_W-1:0]] <= '0;
                        if (cnt_reg == CNT_LAST) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/ltx_checker.sv */
// Port-level assertions for lt_encoded_symbol_xor, with the bind that attaches them.
`timescale 1ns / 1ps

module ltx_checker import ltx_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ltx_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output request changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_burst_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_byte |=> m_valid)
        else $error("gap inside encoded symbol burst");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_byte |=>
            m_data.out_pos == POS_W'($past(m_data.out_pos) + POS_W'(1)))
        else $error("output byte position did not advance by one");

    a_busy_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_byte |-> !s_ready)
        else $error("input taken while symbol still emitting");

endmodule

bind lt_encoded_symbol_xor ltx_checker u_ltx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
